FILE: hdl/fskt_pkg.sv
package fskt_pkg;

  localparam int FIFO_DEPTH_DEF   = 32;
  localparam int MAX_EVENTS_DEF   = 16;
  localparam int PACKET_BYTES_DEF = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PERIOD       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_PERIOD        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_PERIOD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_PER_PACKET = 3'd6;

  localparam logic [15:0] RST_ZERO_PERIOD       = 16'd8;
  localparam logic [15:0] RST_ONE_PERIOD        = 16'd4;
  localparam logic [15:0] RST_PAUSE_PERIOD      = 16'd12;
  localparam logic [14:0] RST_AMPLITUDE         = 15'd16384;
  localparam logic [7:0]  RST_SYNC_FIRST        = 8'd170;
  localparam logic [7:0]  RST_SYNC_SECOND       = 8'd85;
  localparam logic [4:0]  RST_EVENTS_PER_PACKET = 5'd16;

  localparam logic [1:0] SYM_ZERO  = 2'd0;
  localparam logic [1:0] SYM_ONE   = 2'd1;
  localparam logic [1:0] SYM_PAUSE = 2'd2;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef struct packed {
    logic [15:0] zero_period;
    logic [15:0] one_period;
    logic [15:0] pause_period;
    logic [14:0] amplitude;
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [4:0]  events_per_packet;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_HDR,
    ST_POP,
    ST_EV,
    ST_CRC_HI,
    ST_CRC_LO,
    ST_RDBIT,
    ST_BIT,
    ST_DONE
  } state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/fskt_ram.sv
module fskt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/fskt_fifo.sv
module fskt_fifo #(
  parameter int FIFO_DEPTH = fskt_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fskt_pkg::fifo_ctl_t               ctl,
  input  logic [23:0]                       wdata,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]   count,
  output logic [23:0]                       rdata
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (ctl.pop) begin
        rd_ptr <= (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (ctl.push && !ctl.pop) begin
        count <= count + CW'(1);
      end else if (ctl.pop && !ctl.push) begin
        count <= count - CW'(1);
      end
    end
  end

  fskt_ram #(
    .WIDTH(24),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.push),
    .waddr(wr_ptr),
    .wdata(wdata),
    .re   (ctl.pop),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

endmodule

FILE: hdl/fskt_ctrl.sv
module fskt_ctrl #(
  parameter int FIFO_DEPTH   = fskt_pkg::FIFO_DEPTH_DEF,
  parameter int MAX_EVENTS   = fskt_pkg::MAX_EVENTS_DEF,
  parameter int PACKET_BYTES = fskt_pkg::PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fskt_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [23:0]                     event_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              sample,
  output logic                            event_accepted,
  output logic [1:0]                      symbol,
  output fskt_pkg::fifo_ctl_t             fifo_ctl,
  output logic [23:0]                     fifo_wdata,
  input  logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count,
  input  logic [23:0]                     fifo_rdata
);

  localparam int ROOM = (PACKET_BYTES - 5) / 3;
  localparam int CAP  = (MAX_EVENTS < ROOM) ? MAX_EVENTS : ROOM;
  localparam int NW   = $clog2(CAP + 1);
  localparam int PW   = $clog2(3 * CAP + 1);
  localparam int AW   = $clog2(PACKET_BYTES);
  localparam int LW   = $clog2(PACKET_BYTES + 1);
  localparam int BW   = LW + 3;
  localparam int CW   = $clog2(FIFO_DEPTH + 1);

  fskt_pkg::state_t state, state_next;

  logic          item_kind, item_kind_next;
  logic [23:0]   item_word, item_word_next;
  logic [15:0]   hold_count, hold_count_next;
  logic          polarity, polarity_next;
  logic [1:0]    cur_sym, cur_sym_next;
  logic [BW-1:0] bit_index, bit_index_next;
  logic [LW-1:0] pkt_len, pkt_len_next;
  logic [NW-1:0] n_ev, n_ev_next;
  logic [NW-1:0] ev_cnt, ev_cnt_next;
  logic [AW-1:0] wa, wa_next;
  logic [1:0]    bsel, bsel_next;
  logic [15:0]   crc, crc_next;
  logic          accepted, accepted_next;
  logic          out_valid_next;
  logic [15:0]   sample_next;
  logic          event_accepted_next;
  logic [1:0]    symbol_next;

  logic          pkt_we;
  logic [7:0]    pkt_wdata;
  logic          pkt_re;
  logic [7:0]    pkt_rdata;
  logic [NW-1:0] lim;
  logic [NW-1:0] n_take;
  logic [PW-1:0] pay;
  logic [PW-1:0] pay_reg;
  logic [7:0]    ev_byte;
  logic          pkt_bit;

  assign in_ready   = (state == fskt_pkg::ST_IDLE);
  assign fifo_wdata = item_word;
  assign pay_reg    = PW'(3 * n_ev);
  assign pkt_bit    = pkt_rdata[3'd7 - bit_index[2:0]];

  always_comb begin
    if (cfg.events_per_packet == 5'd0) begin
      lim = NW'(1);
    end else if (int'(cfg.events_per_packet) > CAP) begin
      lim = NW'(CAP);
    end else begin
      lim = NW'(cfg.events_per_packet);
    end
    if (int'(fifo_count) < int'(lim)) begin
      n_take = NW'(fifo_count);
    end else begin
      n_take = lim;
    end
    pay = PW'(3 * n_take);
  end

  always_comb begin
    case (bsel)
      2'd0:    ev_byte = fifo_rdata[23:16];
      2'd1:    ev_byte = fifo_rdata[15:8];
      default: ev_byte = fifo_rdata[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fskt_pkg::ST_IDLE;
      hold_count <= 16'd1;
      polarity   <= 1'b0;
      cur_sym    <= fskt_pkg::SYM_PAUSE;
      bit_index  <= '0;
      pkt_len    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      hold_count <= hold_count_next;
      polarity   <= polarity_next;
      cur_sym    <= cur_sym_next;
      bit_index  <= bit_index_next;
      pkt_len    <= pkt_len_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item_kind      <= item_kind_next;
    item_word      <= item_word_next;
    n_ev           <= n_ev_next;
    ev_cnt         <= ev_cnt_next;
    wa             <= wa_next;
    bsel           <= bsel_next;
    crc            <= crc_next;
    accepted       <= accepted_next;
    sample         <= sample_next;
    event_accepted <= event_accepted_next;
    symbol         <= symbol_next;
  end

  always_comb begin
    state_next          = state;
    item_kind_next      = item_kind;
    item_word_next      = item_word;
    hold_count_next     = hold_count;
    polarity_next       = polarity;
    cur_sym_next        = cur_sym;
    bit_index_next      = bit_index;
    pkt_len_next        = pkt_len;
    n_ev_next           = n_ev;
    ev_cnt_next         = ev_cnt;
    wa_next             = wa;
    bsel_next           = bsel;
    crc_next            = crc;
    accepted_next       = accepted;
    out_valid_next      = out_valid && !out_ready;
    sample_next         = sample;
    event_accepted_next = event_accepted;
    symbol_next         = symbol;
    fifo_ctl            = '0;
    pkt_we              = 1'b0;
    pkt_wdata           = 8'd0;
    pkt_re              = 1'b0;

    unique case (state)
      fskt_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_kind_next = kind;
          item_word_next = event_word;
          state_next     = fskt_pkg::ST_DECIDE;
        end
      end
      fskt_pkg::ST_DECIDE: begin
        accepted_next = 1'b0;
        if (item_kind) begin
          if (fifo_count != CW'(FIFO_DEPTH)) begin
            fifo_ctl.push = 1'b1;
            accepted_next = 1'b1;
          end
          state_next = fskt_pkg::ST_DONE;
        end else if (hold_count != 16'd0) begin
          hold_count_next = hold_count - 16'd1;
          state_next      = fskt_pkg::ST_DONE;
        end else begin
          polarity_next = !polarity;
          if (bit_index >= {pkt_len, 3'b000}) begin
            bit_index_next = '0;
            if (n_take == '0) begin
              pkt_len_next    = '0;
              cur_sym_next    = fskt_pkg::SYM_PAUSE;
              hold_count_next = cfg.pause_period - 16'd1;
              state_next      = fskt_pkg::ST_DONE;
            end else begin
              n_ev_next   = n_take;
              ev_cnt_next = '0;
              wa_next     = '0;
              crc_next    = fskt_pkg::crc_byte(fskt_pkg::CRC_INIT, 8'(pay));
              state_next  = fskt_pkg::ST_HDR;
            end
          end else begin
            state_next = fskt_pkg::ST_RDBIT;
          end
        end
      end
      fskt_pkg::ST_HDR: begin
        pkt_we  = 1'b1;
        wa_next = wa + AW'(1);
        case (wa[1:0])
          2'd0:    pkt_wdata = cfg.sync_first;
          2'd1:    pkt_wdata = cfg.sync_second;
          default: pkt_wdata = 8'(pay_reg);
        endcase
        if (wa[1:0] == 2'd2) begin
          state_next = fskt_pkg::ST_POP;
        end
      end
      fskt_pkg::ST_POP: begin
        fifo_ctl.pop = 1'b1;
        bsel_next    = 2'd0;
        state_next   = fskt_pkg::ST_EV;
      end
      fskt_pkg::ST_EV: begin
        pkt_we    = 1'b1;
        pkt_wdata = ev_byte;
        wa_next   = wa + AW'(1);
        crc_next  = fskt_pkg::crc_byte(crc, ev_byte);
        bsel_next = bsel + 2'd1;
        if (bsel == 2'd2) begin
          ev_cnt_next = ev_cnt + NW'(1);
          if (ev_cnt + NW'(1) == n_ev) begin
            state_next = fskt_pkg::ST_CRC_HI;
          end else begin
            state_next = fskt_pkg::ST_POP;
          end
        end
      end
      fskt_pkg::ST_CRC_HI: begin
        pkt_we     = 1'b1;
        pkt_wdata  = crc[15:8];
        wa_next    = wa + AW'(1);
        state_next = fskt_pkg::ST_CRC_LO;
      end
      fskt_pkg::ST_CRC_LO: begin
        pkt_we       = 1'b1;
        pkt_wdata    = crc[7:0];
        pkt_len_next = LW'(pay_reg) + LW'(5);
        state_next   = fskt_pkg::ST_RDBIT;
      end
      fskt_pkg::ST_RDBIT: begin
        pkt_re     = 1'b1;
        state_next = fskt_pkg::ST_BIT;
      end
      fskt_pkg::ST_BIT: begin
        bit_index_next = bit_index + BW'(1);
        if (pkt_bit) begin
          cur_sym_next    = fskt_pkg::SYM_ONE;
          hold_count_next = cfg.one_period - 16'd1;
        end else begin
          cur_sym_next    = fskt_pkg::SYM_ZERO;
          hold_count_next = cfg.zero_period - 16'd1;
        end
        state_next = fskt_pkg::ST_DONE;
      end
      fskt_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next      = 1'b1;
          event_accepted_next = accepted;
          symbol_next         = cur_sym;
          if (item_kind) begin
            sample_next = 16'd0;
          end else if (polarity) begin
            sample_next = 16'd0 - {1'b0, cfg.amplitude};
          end else begin
            sample_next = {1'b0, cfg.amplitude};
          end
          state_next = fskt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fskt_pkg::ST_IDLE;
      end
    endcase
  end

  fskt_ram #(
    .WIDTH(8),
    .DEPTH(PACKET_BYTES)
  ) u_pkt_ram (
    .clk  (clk),
    .we   (pkt_we),
    .waddr(wa),
    .wdata(pkt_wdata),
    .re   (pkt_re),
    .raddr(bit_index[AW+2:3]),
    .rdata(pkt_rdata)
  );

endmodule

FILE: hdl/fsk_packet_transmitter_unit.sv
// An event item, a tick that only counts down and a tick that finds no events to frame pass
// the decide and done states; a symbol fetch adds the packet memory read and bit states, and
// building a packet of n events first adds three header writes, per event one FIFO read and
// three byte writes with a CRC step per byte, and two CRC byte writes. A result waiting at
// the output holds the done state. Items are taken one at a time, the next only when idle.
// Reset (synchronous, active high) restores the register defaults, empties the FIFO and the
// packet, and starts on a pause symbol with positive polarity; no memory clearing is needed.
module fsk_packet_transmitter_unit #(
  parameter int FIFO_DEPTH   = fskt_pkg::FIFO_DEPTH_DEF,
  parameter int MAX_EVENTS   = fskt_pkg::MAX_EVENTS_DEF,
  parameter int PACKET_BYTES = fskt_pkg::PACKET_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [fskt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fskt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [23:0]                       event_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                sample,
  output logic                              event_accepted,
  output logic [1:0]                        symbol
);

  fskt_pkg::cfg_t                    cfg;
  fskt_pkg::fifo_ctl_t               fifo_ctl;
  logic [23:0]                       fifo_wdata;
  logic [23:0]                       fifo_rdata;
  logic [$clog2(FIFO_DEPTH+1)-1:0]   fifo_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_period       <= fskt_pkg::RST_ZERO_PERIOD;
      cfg.one_period        <= fskt_pkg::RST_ONE_PERIOD;
      cfg.pause_period      <= fskt_pkg::RST_PAUSE_PERIOD;
      cfg.amplitude         <= fskt_pkg::RST_AMPLITUDE;
      cfg.sync_first        <= fskt_pkg::RST_SYNC_FIRST;
      cfg.sync_second       <= fskt_pkg::RST_SYNC_SECOND;
      cfg.events_per_packet <= fskt_pkg::RST_EVENTS_PER_PACKET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fskt_pkg::CFG_ZERO_PERIOD:       cfg.zero_period       <= cfg_data;
        fskt_pkg::CFG_ONE_PERIOD:        cfg.one_period        <= cfg_data;
        fskt_pkg::CFG_PAUSE_PERIOD:      cfg.pause_period      <= cfg_data;
        fskt_pkg::CFG_AMPLITUDE:         cfg.amplitude         <= cfg_data[14:0];
        fskt_pkg::CFG_SYNC_FIRST:        cfg.sync_first        <= cfg_data[7:0];
        fskt_pkg::CFG_SYNC_SECOND:       cfg.sync_second       <= cfg_data[7:0];
        fskt_pkg::CFG_EVENTS_PER_PACKET: cfg.events_per_packet <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  fskt_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctl  (fifo_ctl),
    .wdata(fifo_wdata),
    .count(fifo_count),
    .rdata(fifo_rdata)
  );

  fskt_ctrl #(
    .FIFO_DEPTH  (FIFO_DEPTH),
    .MAX_EVENTS  (MAX_EVENTS),
    .PACKET_BYTES(PACKET_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .event_word    (event_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample        (sample),
    .event_accepted(event_accepted),
    .symbol        (symbol),
    .fifo_ctl      (fifo_ctl),
    .fifo_wdata    (fifo_wdata),
    .fifo_count    (fifo_count),
    .fifo_rdata    (fifo_rdata)
  );

endmodule
